// ===== hw/rtl/rhps_pkg.sv =====
package rhps_pkg;

  typedef enum logic [1:0] {
    ACT_GET_STATUS   = 2'd0,
    ACT_CLR_RESET    = 2'd1,
    ACT_CLR_SUSPEND  = 2'd2,
    ACT_MARK_RESET   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    OUT_OK        = 2'd0,
    OUT_SUSPENDED = 2'd1,
    OUT_BAD_PORT  = 2'd2
  } outcome_t;

  // raw portsc bit positions
  localparam int HW_CCS     = 0;
  localparam int HW_CSC     = 1;
  localparam int HW_PED     = 2;
  localparam int HW_PEDC    = 3;
  localparam int HW_LS      = 8;
  localparam int HW_RESET   = 9;
  localparam int HW_SUSPEND = 12;

  // hub status bit positions
  localparam int HS_CONNECT = 0;
  localparam int HS_ENABLE  = 1;
  localparam int HS_SUSPEND = 2;
  localparam int HS_RESET   = 4;
  localparam int HS_POWER   = 8;
  localparam int HS_LOWSPD  = 9;

  localparam int ST_W = 10;

  typedef struct packed {
    logic [ST_W-1:0] last;
    logic            susp_chg;
    logic            was_rst;
  } port_state_t;

  typedef struct packed {
    logic [15:0]  status;
    logic [15:0]  change;
    outcome_t     outcome;
    logic         wr_en;
    port_state_t  state_nxt;
  } xlate_res_t;

endpackage

// ===== hw/rtl/rhps_xlate.sv =====
module rhps_xlate (
  input  rhps_pkg::action_t     action,
  input  logic                  port_ok,
  input  logic                  suspended,
  input  logic [15:0]           hw,
  input  rhps_pkg::port_state_t state,
  output rhps_pkg::xlate_res_t  res
);
  import rhps_pkg::*;

  logic [15:0] status;
  logic [15:0] last16;
  logic [15:0] change;
  logic        susp_chg;

  always_comb begin
    status = '0;
    status[HS_POWER]   = 1'b1;
    status[HS_SUSPEND] = hw[HW_SUSPEND];
    status[HS_RESET]   = hw[HW_RESET];
    status[HS_LOWSPD]  = hw[HW_LS];
    status[HS_ENABLE]  = hw[HW_PED];
    status[HS_CONNECT] = hw[HW_CCS];

    last16 = {{(16-ST_W){1'b0}}, state.last};
    change = status ^ last16;
    change[HS_ENABLE]  = hw[HW_PEDC];
    change[HS_CONNECT] = hw[HW_CSC];

    // sticky flag sets on a suspend to resume transition
    susp_chg = state.susp_chg | (last16[HS_SUSPEND] & ~status[HS_SUSPEND]);
    change[HS_SUSPEND] = susp_chg;
    if (state.was_rst) begin
      change[HS_RESET] = 1'b1;
    end

    res.status    = '0;
    res.change    = '0;
    res.outcome   = OUT_OK;
    res.wr_en     = 1'b0;
    res.state_nxt = state;

    if (action == ACT_GET_STATUS && suspended) begin
      res.outcome = OUT_SUSPENDED;
    end else if (!port_ok) begin
      res.outcome = OUT_BAD_PORT;
    end else begin
      res.wr_en = 1'b1;
      case (action)
        ACT_GET_STATUS: begin
          res.status             = status;
          res.change             = change;
          res.state_nxt.last     = status[ST_W-1:0];
          res.state_nxt.susp_chg = susp_chg;
        end
        ACT_CLR_RESET:   res.state_nxt.was_rst  = 1'b0;
        ACT_CLR_SUSPEND: res.state_nxt.susp_chg = 1'b0;
        ACT_MARK_RESET:  res.state_nxt.was_rst  = 1'b1;
        default:         res.wr_en              = 1'b0;
      endcase
    end
  end

endmodule

// ===== hw/rtl/root_hub_port_status_synth.sv =====
// path: input transfer -> input register -> result register, where the result is valid
// throughput: one item per cycle while out_tready does not stall the output; the per-port
// flag read-modify-write sits between the input and result registers
// reset: synchronous active-low rst_n clears valids, per-port state and the
// suspend register; no clearing pass is needed
module root_hub_port_status_synth #(
  parameter int PORT_COUNT = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,   // power_suspended
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [2:0] port, [18:3] port_control, rest zero
  input  logic [1:0]  in_tuser,      // [1:0] action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata      // [15:0] port_status, [31:16] port_change, [33:32] outcome
);
  import rhps_pkg::*;

  localparam int IDX_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

  logic        susp_r;
  logic        in_valid_r;
  action_t     action_r;
  logic [2:0]  port_r;
  logic [15:0] hw_r;
  logic        out_valid_r;
  logic [39:0] out_data_r;

  port_state_t state_r [PORT_COUNT];

  logic        advance;
  logic        port_ok;
  logic [2:0]  port_m1;
  logic [IDX_W-1:0] idx;
  port_state_t cur_state;
  xlate_res_t  res;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  assign port_ok = (port_r != 3'd0) && (port_r <= 3'(PORT_COUNT));
  assign port_m1 = port_r - 3'd1;
  assign idx     = port_m1[IDX_W-1:0];

  always_comb begin
    cur_state = '0;
    for (int i = 0; i < PORT_COUNT; i++) begin
      if (idx == IDX_W'(i)) begin
        cur_state = state_r[i];
      end
    end
  end

  rhps_xlate u_xlate (
    .action    (action_r),
    .port_ok   (port_ok),
    .suspended (susp_r),
    .hw        (hw_r),
    .state     (cur_state),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      susp_r      <= 1'b0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < PORT_COUNT; i++) begin
        state_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        susp_r <= cfg_wr_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r && res.wr_en && port_ok) begin
          for (int i = 0; i < PORT_COUNT; i++) begin
            if (idx == IDX_W'(i)) begin
              state_r[i] <= res.state_nxt;
            end
          end
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      action_r <= action_t'(in_tuser);
      port_r   <= in_tdata[2:0];
      hw_r     <= in_tdata[18:3];
    end
    if (advance && in_valid_r) begin
      out_data_r <= {6'd0, res.outcome, res.change, res.status};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
